// ===== sv/bqdb_pkg.sv =====
// Shared types, constants and tables for the biquad cascade magnitude block.
`default_nettype none
package bqdb_pkg;

  localparam int DEFAULT_MAX_SECTIONS = 8;

  localparam int COEF_W = 32;   // Q4.28 coefficient
  localparam int CS_W   = 34;   // CORDIC x/y/z width, Q2.30 plus headroom
  localparam int MUL_W  = 34;   // shared signed multiplier operand width
  localparam int LOG_W  = 24;   // log2 result, signed Q8.16
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [CS_W-1:0]  CORDIC_START   = 34'sd652032874;
  localparam logic signed [MUL_W-1:0] DB_PER_LOG2_Q24 = 34'sd50504453;
  localparam logic signed [15:0]      FLOOR_DB_RESET  = -16'sd15360;
  localparam logic signed [COEF_W-1:0] ONE_Q28        = 32'sh1000_0000;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // configuration register indexes
  localparam logic REG_SECTION_COUNT = 1'b0;
  localparam logic REG_FLOOR_DB      = 1'b1;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_CHECK,
    ST_DEN_MUL,
    ST_DEN_LOG,
    ST_NUM_MUL,
    ST_NUM_LOG,
    ST_ROT,
    ST_HOME,
    ST_SCALE,
    ST_FINAL
  } state_e;

  typedef enum logic [2:0] {
    LG_IDLE,
    LG_NORM1,
    LG_SQ,
    LG_NORM2,
    LG_ROUND,
    LG_DONE
  } log_state_e;

  // atan(2^-i) with one turn = 2^32
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bqdb_cell.sv =====
// One coefficient cell of the section ring: load port and shift from neighbor.
`default_nettype none
module bqdb_cell
  import bqdb_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  coef_t       load_i,
  input  coef_t       shift_i,
  output coef_t       coef_o
);

  coef_t coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (ctrl_i.load) begin
      coef_d = load_i;
    end else if (ctrl_i.shift) begin
      coef_d = shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{b0: ONE_Q28, b1: '0, b2: '0, a1: '0, a2: '0};
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

// ===== sv/bqdb_cordic.sv =====
// Iterative 30-step CORDIC giving cos/sin in Q2.30 of a 32-bit turn angle.
`default_nettype none
module bqdb_cordic
  import bqdb_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  wire  [31:0]            angle_i,
  output logic                   done_o,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   flip_q, flip_d;
  logic [4:0]             iter_q, iter_d;
  logic signed [CS_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [CS_W-1:0] z_in, dx, dy, at;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    flip_d = flip_q;
    iter_d = iter_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    z_in   = CS_W'($signed(angle_i));
    dx     = y_q >>> iter_q;
    dy     = x_q >>> iter_q;
    at     = CS_W'(atan_turn(iter_q));
    if (start_i) begin
      // fold into +-quarter turn, negate at the end
      flip_d = 1'b0;
      z_d    = z_in;
      if (z_in > CS_W'(34'sh4000_0000)) begin
        z_d    = z_in - CS_W'(34'sh8000_0000);
        flip_d = 1'b1;
      end else if (z_in < -CS_W'(34'sh4000_0000)) begin
        z_d    = z_in + CS_W'(34'sh8000_0000);
        flip_d = 1'b1;
      end
      x_d    = CORDIC_START;
      y_d    = '0;
      iter_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      iter_d = iter_q + 5'd1;
      if (iter_q == 5'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      iter_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      flip_q <= flip_d;
      iter_q <= iter_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

// ===== sv/bqdb_log2.sv =====
// Multi-cycle log2 of re^2+im^2 (parts at 2^-58), Q16 result, zero detect.
`default_nettype none
module bqdb_log2
  import bqdb_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire  signed [63:0]      re_i,
  input  wire  signed [63:0]      im_i,
  output logic                    done_o,
  output logic                    zero_o,
  output logic signed [LOG_W-1:0] value_o
);

  log_state_e state_q, state_d;
  logic [63:0] ur_q, ur_d, ui_q, ui_d, m_q, m_d, y_q, y_d, prod_q;
  logic [5:0]  s_q, s_d, l_q, l_d;
  logic [4:0]  step_q, step_d;
  logic [15:0] frac_q, frac_d;
  logic        zero_q, zero_d;
  logic [63:0] abs_re, abs_im, abs_max;
  logic [6:0]  k;
  logic [31:0] mul_a, mul_b, xn;
  logic        bit_r;
  logic signed [9:0] expo;

  always_comb begin
    state_d = state_q;
    ur_d    = ur_q;
    ui_d    = ui_q;
    m_d     = m_q;
    y_d     = y_q;
    s_d     = s_q;
    l_d     = l_q;
    step_d  = step_q;
    frac_d  = frac_q;
    zero_d  = zero_q;
    abs_re  = re_i[63] ? (64'd0 - re_i) : re_i;
    abs_im  = im_i[63] ? (64'd0 - im_i) : im_i;
    abs_max = (abs_re > abs_im) ? abs_re : abs_im;
    k       = 7'd32 >> step_q[2:0];
    bit_r   = prod_q[63];
    xn      = bit_r ? prod_q[63:32] : prod_q[62:31];
    mul_a   = xn;
    mul_b   = xn;
    case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          ur_d    = abs_re;
          ui_d    = abs_im;
          m_d     = abs_max;
          s_d     = '0;
          l_d     = '0;
          step_d  = '0;
          frac_d  = '0;
          zero_d  = (abs_max == 64'd0);
          state_d = (abs_max == 64'd0) ? LG_DONE : LG_NORM1;
        end
      end
      LG_NORM1: begin
        // least right shift leaving the larger part below 2^31
        if ((m_q >> (k + 7'd30)) != 64'd0) begin
          m_d  = m_q >> k;
          ur_d = ur_q >> k;
          ui_d = ui_q >> k;
          s_d  = s_q + k[5:0];
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd5) begin
          step_d  = '0;
          state_d = LG_SQ;
        end
      end
      LG_SQ: begin
        mul_a  = (step_q == 5'd0) ? ur_q[31:0] : ui_q[31:0];
        mul_b  = mul_a;
        step_d = step_q + 5'd1;
        if (step_q == 5'd1) begin
          y_d = prod_q;
        end else if (step_q == 5'd2) begin
          y_d     = y_q + prod_q;
          step_d  = '0;
          state_d = LG_NORM2;
        end
      end
      LG_NORM2: begin
        // left-justify the sum
        if ((y_q >> (7'd64 - k)) == 64'd0) begin
          y_d = y_q << k;
          l_d = l_q + k[5:0];
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd5) begin
          step_d  = '0;
          state_d = LG_ROUND;
        end
      end
      LG_ROUND: begin
        if (step_q == 5'd0) begin
          mul_a = y_q[63:32];
          mul_b = y_q[63:32];
        end else begin
          frac_d = {frac_q[14:0], bit_r};
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd16) begin
          state_d = LG_DONE;
        end
      end
      LG_DONE: begin
        state_d = LG_IDLE;
      end
      default: begin
        state_d = LG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      ur_q    <= '0;
      ui_q    <= '0;
      m_q     <= '0;
      y_q     <= '0;
      s_q     <= '0;
      l_q     <= '0;
      step_q  <= '0;
      frac_q  <= '0;
      zero_q  <= 1'b0;
      prod_q  <= '0;
    end else begin
      state_q <= state_d;
      ur_q    <= ur_d;
      ui_q    <= ui_d;
      m_q     <= m_d;
      y_q     <= y_d;
      s_q     <= s_d;
      l_q     <= l_d;
      step_q  <= step_d;
      frac_q  <= frac_d;
      zero_q  <= zero_d;
      prod_q  <= 64'(mul_a) * 64'(mul_b);
    end
  end

  // exponent: (63 - L) - 116 + 2s
  assign expo    = $signed({3'b000, s_q, 1'b0}) - $signed({4'b0000, l_q}) - 10'sd53;
  assign value_o = {expo[7:0], frac_q};
  assign zero_o  = zero_q;
  assign done_o  = (state_q == LG_DONE);

endmodule
`default_nettype wire

// ===== sv/biquad_cascade_magnitude_db.sv =====
// Top level: biquad cascade magnitude response in dB over a ring of section cells.
// Usage
//   Input channel (in_valid_i/in_ready_o): one transaction is either a load
//   (opcode 0: section_index and five Q4.28 coefficients, no result) or an
//   evaluate (opcode 1: freq_phase, 65536 = sample rate, one result).
//   Output channel (out_valid_o/out_ready_i): magnitude_db (Q8.8) and the
//   saturated flag. Config port: cfg_we_i writes section_count (index 0) or
//   floor_db (index 1) from cfg_wdata_i; users write only while idle (unchecked).
// Sequence
//   A load writes the addressed cell. An evaluate runs the two 30-step
//   CORDICs, then per section two complex products on the shared multiplier
//   and two passes of the log2 unit (one if the denominator is zero),
//   then the ring step. The ring then rotates home and the sum is scaled
//   before the result register loads. One evaluate is in flight at a time.
// Reset: every slot holds a unity section (b0 = 1.0), section_count is 0
//   and floor_db is -60 dB.
// Backpressure: the result sits in an output register; the block takes a new
//   transaction while it waits, and a finished evaluate holds until it frees.
`default_nettype none
module biquad_cascade_magnitude_db
  import bqdb_pkg::*;
#(
  parameter int MAX_SECTIONS = DEFAULT_MAX_SECTIONS
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire                cfg_index_i,
  input  wire  [15:0]        cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [0:0]         opcode_i,
  input  wire  [2:0]         section_index_i,
  input  wire  signed [31:0] coef_b0_i,
  input  wire  signed [31:0] coef_b1_i,
  input  wire  signed [31:0] coef_b2_i,
  input  wire  signed [31:0] coef_a1_i,
  input  wire  signed [31:0] coef_a2_i,
  input  wire  [15:0]        freq_phase_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] magnitude_db_o,
  output logic               saturated_o
);

  localparam int SEC_W = $clog2(MAX_SECTIONS + 1);
  localparam int CW    = (SEC_W > 4) ? SEC_W : 4;
  localparam int TOT_W = LOG_W + 1 + $clog2(MAX_SECTIONS);

  // ---------------------------------------------------------------- config
  logic [3:0]        count_q;
  logic signed [15:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      floor_q <= FLOOR_DB_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_SECTION_COUNT) begin
        count_q <= cfg_wdata_i[3:0];
      end else if (cfg_index_i == REG_FLOOR_DB) begin
        floor_q <= cfg_wdata_i;
      end
    end
  end

  // ---------------------------------------------------------------- control
  state_e state_q, state_d;
  logic   in_fire, load_fire, eval_fire, rotate;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (opcode_i == OP_LOAD);
  assign eval_fire  = in_fire && (opcode_i == OP_EVAL);

  // ---------------------------------------------------------------- cell ring
  // Cell 0 is the head; a rotation moves every cell one place toward it.
  coef_t coef_in, head;
  coef_t cell_coef [MAX_SECTIONS];

  assign coef_in = '{b0: coef_b0_i, b1: coef_b1_i, b2: coef_b2_i,
                     a1: coef_a1_i, a2: coef_a2_i};
  assign head    = cell_coef[0];

  for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.load  = load_fire && (int'(section_index_i) == k);
    assign ctrl.shift = rotate;
    bqdb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .load_i  (coef_in),
      .shift_i (cell_coef[(k + 1) % MAX_SECTIONS]),
      .coef_o  (cell_coef[k])
    );
  end

  // ---------------------------------------------------------------- CORDIC
  logic                   c1_done, c2_done;
  logic signed [CS_W-1:0] c1, s1, c2, s2;

  bqdb_cordic u_cordic1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eval_fire),
    .angle_i ({freq_phase_i, 16'h0000}),
    .done_o  (c1_done),
    .cos_o   (c1),
    .sin_o   (s1)
  );

  bqdb_cordic u_cordic2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eval_fire),
    .angle_i ({freq_phase_i[14:0], 17'h00000}),
    .done_o  (c2_done),
    .cos_o   (c2),
    .sin_o   (s2)
  );

  // ---------------------------------------------------------------- log2 unit
  logic                    lg_start, lg_done, lg_zero;
  logic signed [LOG_W-1:0] lg_value;
  logic signed [63:0]      re_q, re_d, im_q, im_d;

  bqdb_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .re_i    (re_q),
    .im_i    (im_q),
    .done_o  (lg_done),
    .zero_o  (lg_zero),
    .value_o (lg_value)
  );

  // ---------------------------------------------------------------- datapath
  logic [SEC_W-1:0]        n_q, n_d, sec_q, sec_d, rot_q, rot_d;
  logic [2:0]              step_q, step_d;
  logic                    den_zero_q, den_zero_d, num_zero_q, num_zero_d;
  logic signed [LOG_W-1:0] ld_q, ld_d;
  logic signed [TOT_W-1:0] total_q, total_d;
  logic signed [63:0]      prod_q;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic                    is_num;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [CS_W-1:0]  trig_sel;
  logic [CW-1:0]           count_ext;
  logic signed [63:0]      rnd;
  logic signed [31:0]      q32, qf, floor32;
  logic                    out_valid_q, out_valid_d, sat_q, sat_d;
  logic signed [15:0]      mag_q, mag_d;

  assign count_ext = CW'(count_q);
  assign is_num    = (state_q == ST_NUM_MUL);
  assign lg_start  = (state_q == ST_DEN_MUL || state_q == ST_NUM_MUL) && (step_q == 3'd5);
  assign mul_p     = mul_a * mul_b;
  assign rnd       = prod_q + 64'sh8000_0000;
  assign q32       = rnd[63:32];
  assign floor32   = 32'(floor_q);
  assign qf        = (q32 < floor32) ? floor32 : q32;

  always_comb begin
    // product order: re gets the cosine terms, im the sine terms
    coef_sel = is_num ? (step_q[0] ? head.b2 : head.b1)
                      : (step_q[0] ? head.a2 : head.a1);
    case (step_q[1:0])
      2'd0:    trig_sel = c1;
      2'd1:    trig_sel = c2;
      2'd2:    trig_sel = s1;
      default: trig_sel = s2;
    endcase
    // scaling product stays in prod_q while the result waits in ST_FINAL
    if (state_q == ST_SCALE || state_q == ST_FINAL) begin
      mul_a = MUL_W'(total_q);
      mul_b = DB_PER_LOG2_Q24;
    end else begin
      mul_a = MUL_W'(coef_sel);
      mul_b = MUL_W'(trig_sel);
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    sec_d       = sec_q;
    rot_d       = rot_q;
    step_d      = step_q;
    den_zero_d  = den_zero_q;
    num_zero_d  = num_zero_q;
    ld_d        = ld_q;
    total_d     = total_q;
    re_d        = re_q;
    im_d        = im_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mag_d       = mag_q;
    sat_d       = sat_q;
    rotate      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (eval_fire) begin
          n_d        = (count_ext > CW'(MAX_SECTIONS)) ? SEC_W'(MAX_SECTIONS)
                                                      : SEC_W'(count_ext);
          sec_d      = '0;
          rot_d      = '0;
          den_zero_d = 1'b0;
          num_zero_d = 1'b0;
          total_d    = '0;
          state_d    = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (c1_done && c2_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sec_q == n_q) begin
          state_d = ST_HOME;
        end else begin
          re_d    = 64'sd1 <<< 58;
          im_d    = '0;
          step_d  = '0;
          state_d = ST_DEN_MUL;
        end
      end
      ST_DEN_MUL, ST_NUM_MUL: begin
        // products at steps 0..3, accumulate one step later
        if (step_q != 3'd0 && step_q != 3'd5) begin
          if (step_q < 3'd3) begin
            re_d = re_q + prod_q;
          end else begin
            im_d = im_q + prod_q;
          end
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd5) begin
          step_d  = '0;
          state_d = (state_q == ST_DEN_MUL) ? ST_DEN_LOG : ST_NUM_LOG;
        end
      end
      ST_DEN_LOG: begin
        if (lg_done) begin
          if (lg_zero) begin
            den_zero_d = 1'b1;
            state_d    = ST_ROT;
          end else begin
            ld_d    = lg_value;
            re_d    = 64'(head.b0) <<< 30;
            im_d    = '0;
            state_d = ST_NUM_MUL;
          end
        end
      end
      ST_NUM_LOG: begin
        if (lg_done) begin
          if (lg_zero) begin
            num_zero_d = 1'b1;
          end else begin
            total_d = total_q + TOT_W'(lg_value) - TOT_W'(ld_q);
          end
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        rotate  = 1'b1;
        sec_d   = sec_q + SEC_W'(1);
        rot_d   = rot_q + SEC_W'(1);
        state_d = ST_CHECK;
      end
      ST_HOME: begin
        // finish a full turn so slot k is back in cell k
        if (rot_q == SEC_W'(MAX_SECTIONS)) begin
          state_d = ST_SCALE;
        end else begin
          rotate = 1'b1;
          rot_d  = rot_q + SEC_W'(1);
        end
      end
      ST_SCALE: begin
        state_d = ST_FINAL;
      end
      ST_FINAL: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (den_zero_q) begin
            mag_d = 16'sh7FFF;
            sat_d = 1'b1;
          end else if (num_zero_q) begin
            mag_d = floor_q;
            sat_d = 1'b0;
          end else if (qf > 32'sd32767) begin
            mag_d = 16'sh7FFF;
            sat_d = 1'b1;
          end else begin
            mag_d = qf[15:0];
            sat_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      sec_q       <= '0;
      rot_q       <= '0;
      step_q      <= '0;
      den_zero_q  <= 1'b0;
      num_zero_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      sec_q       <= sec_d;
      rot_q       <= rot_d;
      step_q      <= step_d;
      den_zero_q  <= den_zero_d;
      num_zero_q  <= num_zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q    <= ld_d;
    total_q <= total_d;
    re_q    <= re_d;
    im_q    <= im_d;
    prod_q  <= mul_p[63:0];
    mag_q   <= mag_d;
    sat_q   <= sat_d;
  end

  assign out_valid_o    = out_valid_q;
  assign magnitude_db_o = mag_q;
  assign saturated_o    = sat_q;

endmodule
`default_nettype wire
